[hw/rtl/ptt_pkg.sv]
// Shared types and constants of the periodic task timer table.
package ptt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 40;
    localparam int M_TUSER_W     = 2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADDED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_IDLE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        logic [31:0]       id;
        logic [31:0]       last;
        logic [15:0]       interval;
        logic              limited;
        logic [15:0]       left;
        logic [SLOT_W-1:0] slot;
    } entry_data_t;

    typedef struct packed {
        logic        valid;
        entry_data_t data;
    } entry_t;

    typedef struct packed {
        cell_op_t    op;
        entry_data_t new_data;
        entry_data_t recirc;
        logic        recirc_keep;
    } cell_cmd_t;

endpackage

[hw/rtl/periodic_task_timer_table.sv]
// Top level of the periodic task timer table: a sorted chain of timer cells and its sequencer.
//
// The input channel (s_*) carries commands. s_tuser selects the command: an add stores a
// timer with its interval and repeat count, a tick advances the seconds counter by one.
// The result channel (m_*) carries one transaction per add (the new task id, or table
// full) and, for a tick, one transaction per timer that fired, in ascending id order, or
// a single idle transaction when nothing fired. m_tlast marks the final transaction that
// one command causes.
// The timers live in a chain of cells kept sorted by (id, slot). An add inserts into the
// chain when accepted; its result passes through the pending register into the output
// register, and the next command is accepted once that result is loaded. A tick rotates
// the chain one cell per cycle through the head, where the firing test runs, unless a
// stalled receiver holds the walk; it visits each stored timer once (at most TABLE_ENTRIES).
// Each firing is held one step so that the last one can carry m_tlast.
// Only one command is in work at a time; s_tready is high whenever the block is idle, even
// while a finished result still waits in the output register.
// When the receiver stalls, the output register holds its transaction and the tick walk
// pauses before it would overwrite it.
// Reset empties the table and clears the seconds counter and the id counter.
module periodic_task_timer_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] start_immediately, [16:1] interval, [32:17] repeat_count, [39:33] zero
    input  logic [ptt_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] task_id, [32] entry_removed, [39:33] zero
    output logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [ptt_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    ptt_pkg::cell_cmd_t cmd;
    ptt_pkg::entry_t    cell_ent   [ptt_pkg::TABLE_ENTRIES];
    logic               cell_after [ptt_pkg::TABLE_ENTRIES];

    // Each cell sees its lower neighbor for inserts and its upper neighbor for rotation.
    for (genvar i = 0; i < ptt_pkg::TABLE_ENTRIES; i++) begin : g_cell
        ptt_pkg::entry_t prev_ent;
        logic            prev_after;
        ptt_pkg::entry_t next_ent;

        if (i == 0) begin : g_first
            assign prev_ent   = '0;
            assign prev_after = 1'b0;
        end else begin : g_inner
            assign prev_ent   = cell_ent[i-1];
            assign prev_after = cell_after[i-1];
        end

        if (i == ptt_pkg::TABLE_ENTRIES - 1) begin : g_last
            assign next_ent = '0;
        end else begin : g_body
            assign next_ent = cell_ent[i+1];
        end

        ptt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .prev_ent   (prev_ent),
            .prev_after (prev_after),
            .next_ent   (next_ent),
            .ent        (cell_ent[i]),
            .after      (cell_after[i])
        );
    end

    ptt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .head_ent (cell_ent[0]),
        .cmd      (cmd)
    );

endmodule

[hw/rtl/ptt_cell.sv]
// One cell of the sorted timer chain: holds one entry and trades it with its neighbors.
module ptt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptt_pkg::cell_cmd_t cmd,
    input  ptt_pkg::entry_t    prev_ent,
    input  logic               prev_after,
    input  ptt_pkg::entry_t    next_ent,
    output ptt_pkg::entry_t    ent,
    output logic               after
);

    logic                 valid_reg;
    logic                 valid_next;
    ptt_pkg::entry_data_t data_reg;
    ptt_pkg::entry_data_t data_next;

    // The new entry belongs at or before this position when this cell is empty
    // or holds a larger (id, slot) key.
    assign after = !valid_reg ||
                   ({data_reg.id, data_reg.slot} > {cmd.new_data.id, cmd.new_data.slot});

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (cmd.op)
            ptt_pkg::OP_INSERT: begin
                if (after) begin
                    if (!prev_after) begin
                        valid_next = 1'b1;
                        data_next  = cmd.new_data;
                    end else begin
                        valid_next = prev_ent.valid;
                        data_next  = prev_ent.data;
                    end
                end
            end
            ptt_pkg::OP_ROTATE: begin
                if (valid_reg && !next_ent.valid && cmd.recirc_keep) begin
                    valid_next = 1'b1;
                    data_next  = cmd.recirc;
                end else begin
                    valid_next = next_ent.valid;
                    data_next  = next_ent.data;
                end
            end
            default: begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign ent.valid = valid_reg;
    assign ent.data  = data_reg;

endmodule

[hw/rtl/ptt_ctrl.sv]
// Sequencer of the timer table: commands, tick walk, pending result and output register.
module ptt_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ptt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ptt_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [ptt_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                              m_tlast,
    input  ptt_pkg::entry_t                   head_ent,
    output ptt_pkg::cell_cmd_t                cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t                               state_reg, state_next;
    logic [31:0]                          now_reg, now_next;
    logic [31:0]                          next_id_reg, next_id_next;
    logic [ptt_pkg::CNT_W-1:0]            count_reg, count_next;
    logic [ptt_pkg::CNT_W-1:0]            steps_reg, steps_next;
    logic [ptt_pkg::TABLE_ENTRIES-1:0]    used_reg, used_next;
    logic                                 pend_valid_reg, pend_valid_next;
    ptt_pkg::kind_t                       pend_kind_reg, pend_kind_next;
    logic [31:0]                          pend_id_reg, pend_id_next;
    logic                                 pend_removed_reg, pend_removed_next;
    logic                                 m_valid_reg, m_valid_next;
    ptt_pkg::kind_t                       m_kind_reg, m_kind_next;
    logic [31:0]                          m_id_reg, m_id_next;
    logic                                 m_removed_reg, m_removed_next;
    logic                                 m_last_reg, m_last_next;

    logic                                 in_fire;
    logic                                 in_start;
    logic [15:0]                          in_interval;
    logic [15:0]                          in_repeat;
    logic                                 full;
    logic [ptt_pkg::SLOT_W-1:0]           free_slot;
    logic                                 out_free;
    logic [31:0]                          elapsed;
    logic                                 due;
    logic                                 drop;
    logic                                 step_go;

    assign in_start    = s_tdata[0];
    assign in_interval = s_tdata[16:1];
    assign in_repeat   = s_tdata[32:17];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign full     = (count_reg == ptt_pkg::CNT_W'(ptt_pkg::TABLE_ENTRIES));
    assign out_free = !m_valid_reg || m_tready;

    // Lowest free slot.
    always_comb begin
        free_slot = '0;
        for (int s = ptt_pkg::TABLE_ENTRIES - 1; s >= 0; s--) begin
            if (!used_reg[s]) begin
                free_slot = ptt_pkg::SLOT_W'(s);
            end
        end
    end

    // The head cell holds the next entry in (id, slot) order during a tick walk.
    assign elapsed = now_reg - head_ent.data.last;
    assign due     = (elapsed >= {16'd0, head_ent.data.interval});
    assign drop    = due && head_ent.data.limited && (head_ent.data.left == 16'd1);
    assign step_go = !(due && pend_valid_reg) || out_free;

    always_comb begin
        state_next        = state_reg;
        now_next          = now_reg;
        next_id_next      = next_id_reg;
        count_next        = count_reg;
        steps_next        = steps_reg;
        used_next         = used_reg;
        pend_valid_next   = pend_valid_reg;
        pend_kind_next    = pend_kind_reg;
        pend_id_next      = pend_id_reg;
        pend_removed_next = pend_removed_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_kind_next       = m_kind_reg;
        m_id_next         = m_id_reg;
        m_removed_next    = m_removed_reg;
        m_last_next       = m_last_reg;

        cmd.op                = ptt_pkg::OP_HOLD;
        cmd.new_data.id       = next_id_reg + 32'd1;
        cmd.new_data.last     = in_start ? (now_reg - {16'd0, in_interval}) : now_reg;
        cmd.new_data.interval = in_interval;
        cmd.new_data.limited  = (in_repeat != 16'd0);
        cmd.new_data.left     = in_repeat;
        cmd.new_data.slot     = free_slot;
        cmd.recirc            = head_ent.data;
        cmd.recirc_keep       = !drop;
        if (due) begin
            cmd.recirc.last = now_reg;
            if (head_ent.data.limited) begin
                cmd.recirc.left = head_ent.data.left - 16'd1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == ptt_pkg::CMD_TICK) begin
                        now_next        = now_reg + 32'd1;
                        steps_next      = count_reg;
                        pend_valid_next = 1'b0;
                        state_next      = ST_RUN;
                    end else begin
                        pend_valid_next   = 1'b1;
                        pend_removed_next = 1'b0;
                        if (full) begin
                            pend_kind_next = ptt_pkg::KIND_FULL;
                            pend_id_next   = 32'd0;
                        end else begin
                            cmd.op                = ptt_pkg::OP_INSERT;
                            next_id_next          = next_id_reg + 32'd1;
                            count_next            = count_reg + ptt_pkg::CNT_W'(1);
                            used_next[free_slot]  = 1'b1;
                            pend_kind_next        = ptt_pkg::KIND_ADDED;
                            pend_id_next          = next_id_reg + 32'd1;
                        end
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_RUN: begin
                if (steps_reg == '0) begin
                    state_next = ST_FLUSH;
                end else if (step_go) begin
                    cmd.op     = ptt_pkg::OP_ROTATE;
                    steps_next = steps_reg - ptt_pkg::CNT_W'(1);
                    if (due) begin
                        if (pend_valid_reg) begin
                            m_valid_next   = 1'b1;
                            m_kind_next    = pend_kind_reg;
                            m_id_next      = pend_id_reg;
                            m_removed_next = pend_removed_reg;
                            m_last_next    = 1'b0;
                        end
                        pend_valid_next   = 1'b1;
                        pend_kind_next    = ptt_pkg::KIND_FIRED;
                        pend_id_next      = head_ent.data.id;
                        pend_removed_next = drop;
                        if (drop) begin
                            count_next                   = count_reg - ptt_pkg::CNT_W'(1);
                            used_next[head_ent.data.slot] = 1'b0;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_kind_next    = pend_kind_reg;
                        m_id_next      = pend_id_reg;
                        m_removed_next = pend_removed_reg;
                    end else begin
                        m_kind_next    = ptt_pkg::KIND_IDLE;
                        m_id_next      = 32'd0;
                        m_removed_next = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= 32'd0;
            next_id_reg    <= 32'd0;
            count_reg      <= '0;
            steps_reg      <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            next_id_reg    <= next_id_next;
            count_reg      <= count_next;
            steps_reg      <= steps_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_kind_reg    <= pend_kind_next;
        pend_id_reg      <= pend_id_next;
        pend_removed_reg <= pend_removed_next;
        m_kind_reg       <= m_kind_next;
        m_id_reg         <= m_id_next;
        m_removed_reg    <= m_removed_next;
        m_last_reg       <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {7'd0, m_removed_reg, m_id_reg};
    assign m_tlast  = m_last_reg;

endmodule

[hw/rtl/ptt_checker.sv]
// Port-level assertions of the timer table, bound to the top level.
module ptt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ptt_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // An accepted command keeps the input closed for at least the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after a command");

    // A stalled result transaction keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // Only a firing can be followed by more results of the same command.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ptt_pkg::KIND_FIRED) |-> m_tlast)
        else $error("non-firing result without last flag");

    // Only a firing can free an entry.
    a_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ptt_pkg::KIND_FIRED) |-> !m_tdata[32])
        else $error("removal flag on a non-firing result");

    // Idle and full results carry no task id.
    a_noid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == ptt_pkg::KIND_IDLE) || (m_tuser == ptt_pkg::KIND_FULL))
        |-> (m_tdata[31:0] == 32'd0))
        else $error("task id on idle or full result");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (.*);

[sim/tb_periodic_task_timer_table.sv]
// Self-checking testbench for the periodic task timer table: directed rows, then random commands.
module tb_periodic_task_timer_table;
    timeunit 1ns;
    timeprecision 1ps;

    // The receiver's long hold-off, the cycles allowed after the last expected result
    // (a tick walks up to TABLE_ENTRIES cells), and the watchdog limit on cycles in which no
    // transaction is accepted on either side.
    localparam int RANDOM_ITEMS   = 256;
    localparam int HOLD_AT_ITEM   = 80;
    localparam int PAUSE_AT_ITEM  = 120;
    localparam int BURST_FIRST    = 140;
    localparam int BURST_LAST     = 179;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = ptt_pkg::TABLE_ENTRIES + 8;
    localparam int STALL_LIMIT    = 4000;
    localparam int MAX_PRINTED    = 40;
    localparam int KEY_W          = 32 + ptt_pkg::SLOT_W;

    // One result transaction as the block should present it.
    typedef struct packed {
        ptt_pkg::kind_t kind;
        logic [31:0]    task_id;
        logic           removed;
        logic           last;
    } timer_result_t;

    // One command of the directed table. Where typed is set, the single result that the
    // command causes is given in the row (removed is 0 and last is 1 for all of them).
    typedef struct packed {
        logic           cmd;
        logic           start_now;
        logic [15:0]    interval;
        logic [15:0]    repeats;
        logic           typed;
        ptt_pkg::kind_t kind;
        logic [31:0]    task_id;
    } command_row_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [ptt_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ptt_pkg::M_TDATA_W-1:0] m_tdata;
    logic [ptt_pkg::M_TUSER_W-1:0] m_tuser;
    logic                          m_tlast;

    // Shadow copy of the timer table, kept in step with every accepted command.
    logic [31:0] now_sec   = '0;
    logic [31:0] issued_id = '0;
    logic        slot_busy     [ptt_pkg::TABLE_ENTRIES];
    logic [31:0] slot_id       [ptt_pkg::TABLE_ENTRIES];
    logic [31:0] slot_last     [ptt_pkg::TABLE_ENTRIES];
    logic [15:0] slot_interval [ptt_pkg::TABLE_ENTRIES];
    logic        slot_limited  [ptt_pkg::TABLE_ENTRIES];
    logic [15:0] slot_left     [ptt_pkg::TABLE_ENTRIES];

    timer_result_t pending_results[$];

    int error_count  = 0;
    int stall_cycles = 0;

    // Flags shared between the sender and the receiver.
    bit hold_off_req = 1'b0;
    bit full_speed   = 1'b0;

    // The directed rows. The table is brought to full with short-lived limited entries so
    // that it drains again during the random part.
    command_row_t directed_rows [24] = '{
        // A tick straight after reset has nothing to fire.
        '{ptt_pkg::CMD_TICK, 1'b0, 16'h0000, 16'h0000, 1'b1, ptt_pkg::KIND_IDLE,  32'd0},
        // The first id is 1. Interval zero fires on every tick, forever.
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h0000, 16'h0000, 1'b1, ptt_pkg::KIND_ADDED, 32'd1},
        // A tick with all its ignored fields at their maximum.
        '{ptt_pkg::CMD_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        // Largest interval, started immediately, one repeat: fires once and is removed.
        '{ptt_pkg::CMD_ADD,  1'b1, 16'hFFFF, 16'h0001, 1'b1, ptt_pkg::KIND_ADDED, 32'd2},
        '{ptt_pkg::CMD_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h0003, 16'h0002, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b1, 16'h0002, 16'hFFFF, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_TICK, 1'b1, 16'h5A5A, 16'hA5A5, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        // Three entries are live here; thirteen more fill the table.
        '{ptt_pkg::CMD_ADD,  1'b1, 16'h0000, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h0001, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b1, 16'h0005, 16'h0002, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h0002, 16'h0003, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b1, 16'h8000, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h0000, 16'h0002, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b1, 16'h0007, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h0004, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b1, 16'h00FF, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h0001, 16'h0002, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b1, 16'h0003, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h0006, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        '{ptt_pkg::CMD_ADD,  1'b1, 16'h7FFF, 16'h0001, 1'b0, ptt_pkg::KIND_IDLE,  32'd0},
        // The table is full: no id is used up.
        '{ptt_pkg::CMD_ADD,  1'b0, 16'h1234, 16'h0005, 1'b1, ptt_pkg::KIND_FULL,  32'd0},
        // A tick that fires many entries and frees most of them.
        '{ptt_pkg::CMD_TICK, 1'b0, 16'h0000, 16'h0000, 1'b0, ptt_pkg::KIND_IDLE,  32'd0}
    };

    periodic_task_timer_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Works out the results of one accepted command and appends them to pending_results,
    // updating the shadow table on the way.
    task automatic predict_command(input logic cmd, input logic start_now,
                                   input logic [15:0] interval, input logic [15:0] repeats);
        int               free_slot;
        int               best;
        bit               have_prev;
        bit               have_held;
        logic [KEY_W-1:0] prev_key;
        logic [KEY_W-1:0] best_key;
        logic [KEY_W-1:0] key;
        logic [31:0]      elapsed;
        timer_result_t    held;
        timer_result_t    res;

        if (cmd == ptt_pkg::CMD_ADD) begin
            free_slot = -1;
            for (int i = ptt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
                if (!slot_busy[i]) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0) begin
                res = '{ptt_pkg::KIND_FULL, 32'd0, 1'b0, 1'b1};
            end else begin
                issued_id                = issued_id + 32'd1;
                slot_busy[free_slot]     = 1'b1;
                slot_id[free_slot]       = issued_id;
                slot_interval[free_slot] = interval;
                slot_limited[free_slot]  = (repeats != 16'd0);
                slot_left[free_slot]     = repeats;
                // Starting immediately backdates the entry by one interval.
                slot_last[free_slot]     = start_now ? now_sec - {16'd0, interval} : now_sec;
                res = '{ptt_pkg::KIND_ADDED, issued_id, 1'b0, 1'b1};
            end
            pending_results.push_back(res);
        end else begin
            now_sec   = now_sec + 32'd1;
            have_prev = 1'b0;
            have_held = 1'b0;
            prev_key  = '0;
            // Visit the live entries in ascending (id, slot) order. Each firing is held
            // back one step so that the final one can be marked as last.
            for (int pass = 0; pass < ptt_pkg::TABLE_ENTRIES; pass++) begin
                best     = -1;
                best_key = '0;
                for (int i = 0; i < ptt_pkg::TABLE_ENTRIES; i++) begin
                    key = {slot_id[i], ptt_pkg::SLOT_W'(i)};
                    if (slot_busy[i] && !(have_prev && key <= prev_key)
                            && (best < 0 || key < best_key)) begin
                        best     = i;
                        best_key = key;
                    end
                end
                if (best >= 0) begin
                    have_prev = 1'b1;
                    prev_key  = best_key;
                    elapsed   = now_sec - slot_last[best];
                    if (elapsed >= {16'd0, slot_interval[best]}) begin
                        res = '{ptt_pkg::KIND_FIRED, slot_id[best], 1'b0, 1'b0};
                        slot_last[best] = now_sec;
                        if (slot_limited[best]) begin
                            slot_left[best] = slot_left[best] - 16'd1;
                            if (slot_left[best] == 16'd0) begin
                                slot_busy[best] = 1'b0;
                                res.removed     = 1'b1;
                            end
                        end
                        if (have_held) begin
                            pending_results.push_back(held);
                        end
                        held      = res;
                        have_held = 1'b1;
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                pending_results.push_back(held);
            end else begin
                res = '{ptt_pkg::KIND_IDLE, 32'd0, 1'b0, 1'b1};
                pending_results.push_back(res);
            end
        end
    endtask

    // Offers one command after a random gap (none during a hold-off or the burst), waits for
    // the transaction and records what it should cause.
    task automatic send_command(input command_row_t row);
        int            gap;
        int            queued;
        timer_result_t typed_res;

        gap = (hold_off_req || full_speed) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd;
        s_tdata  <= {7'd0, row.repeats, row.interval, row.start_now};
        do begin
            @(posedge aclk);
        end while (!s_tready);

        queued = pending_results.size();
        predict_command(row.cmd, row.start_now, row.interval, row.repeats);
        if (row.typed) begin
            // Rows with a typed-in result replace what the shadow table worked out.
            while (pending_results.size() > queued) begin
                void'(pending_results.pop_back());
            end
            typed_res = '{row.kind, row.task_id, 1'b0, 1'b1};
            pending_results.push_back(typed_res);
        end
    endtask

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
        end
    endtask

    // Stimulus: reset, the directed rows, then random commands with one sender pause
    // and one long receiver hold-off along the way.
    initial begin
        command_row_t row;
        int           roll;

        for (int i = 0; i < ptt_pkg::TABLE_ENTRIES; i++) begin
            slot_busy[i] = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_command(directed_rows[i]);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == HOLD_AT_ITEM) begin
                hold_off_req = 1'b1;
            end
            if (k == PAUSE_AT_ITEM) begin
                // The sender goes quiet until every expected result has come back.
                s_tvalid <= 1'b0;
                do begin
                    @(posedge aclk);
                end while (pending_results.size() != 0);
            end
            full_speed = (k >= BURST_FIRST && k <= BURST_LAST);

            row.cmd       = ($urandom_range(0, 99) < 55) ? ptt_pkg::CMD_TICK : ptt_pkg::CMD_ADD;
            row.start_now = 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                row.interval = 16'($urandom_range(0, 7));
            end else if (roll < 85) begin
                row.interval = 16'($urandom_range(0, 16'hFFFF));
            end else if (roll < 92) begin
                row.interval = 16'hFFFF;
            end else begin
                row.interval = 16'h0000;
            end
            // Mostly short-lived limited entries, so that slots keep coming free.
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                row.repeats = 16'($urandom_range(1, 4));
            end else if (roll < 89) begin
                row.repeats = 16'h0000;
            end else if (roll < 98) begin
                row.repeats = 16'($urandom_range(0, 16'hFFFF));
            end else begin
                row.repeats = 16'hFFFF;
            end
            row.typed   = 1'b0;
            row.kind    = ptt_pkg::KIND_IDLE;
            row.task_id = 32'd0;
            send_command(row);
        end
        full_speed = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: ready, then a random gap, and always ready during the burst. On request it
    // holds off so that the block backs up and stalls its input.
    initial begin
        int gap;

        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (full_speed) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Checker: every accepted result transaction against the oldest expectation.
    always @(posedge aclk) begin
        timer_result_t want;

        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind) begin
                    report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                end
                if (m_tdata[31:0] !== want.task_id) begin
                    report_mismatch("task_id", m_tdata[31:0], want.task_id);
                end
                if (m_tdata[32] !== want.removed) begin
                    report_mismatch("entry_removed", 32'(m_tdata[32]), 32'(want.removed));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last_of_run", 32'(m_tlast), 32'(want.last));
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
